[sv/biggr_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// biggr_pkg
// Shared widths, types and constants of the box IoU / GIoU gradient core.
// ---------------------------------------------------------------------------
package biggr_pkg;

    localparam int EW   = 18;            // edge, 2*center +/- size
    localparam int LW   = 20;            // lengths and edge derivatives
    localparam int AW   = 38;            // areas and union
    localparam int NPW  = AW + LW + 1;   // quotient numerator, signed
    localparam int MW   = 56;            // numerator magnitude
    localparam int DDW  = 74;            // squared denominator
    localparam int SH   = 30;            // numerator scale shift
    localparam int NW   = 88;            // divider dividend
    localparam int DW   = 76;            // divider divisor
    localparam int QW   = 41;            // quotient bits
    localparam int TW   = QW + 1;        // signed term
    localparam int GW   = 32;            // gradient output
    localparam int SW   = TW + 1;        // sum of two terms
    localparam int DIV_LAT = QW + 3;     // divider latency in cycles

    localparam logic [QW-1:0] TERM_LIM = QW'(1) << (QW - 1);
    localparam logic [GW-1:0] G_MAX    = {1'b0, {(GW-1){1'b1}}};
    localparam logic [GW-1:0] G_MIN    = {1'b1, {(GW-1){1'b0}}};

    typedef logic signed [NPW-1:0] t_num;
    typedef logic [DDW-1:0]        t_dd;
    typedef logic signed [TW-1:0]  t_term;

    typedef struct packed {
        logic valid;
        logic en;
    } t_div_ctl;

    typedef struct packed {
        logic valid;
        logic sat;
    } t_div_sts;

endpackage
`default_nettype wire

[sv/biggr_div.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// biggr_div
// Pipelined rounded quotient |n| * 2^29 / d^2, one quotient bit per stage,
// magnitude clipped to 2^40, sign of n restored at the output, zero when en is low.
// ---------------------------------------------------------------------------
module biggr_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire biggr_pkg::t_div_ctl i_ctl,
    input  wire biggr_pkg::t_num    i_num,
    input  wire biggr_pkg::t_dd     i_dd,
    output biggr_pkg::t_div_sts     o_sts,
    output biggr_pkg::t_term        o_term
);
    import biggr_pkg::*;

    logic [MW-1:0]  w_mag;
    logic [NW-1:0]  n_p_num;
    logic           r_p_v, r_p_en, r_p_neg;
    logic [NW-1:0]  r_p_num;
    logic [DW-1:0]  r_p_den;
    logic [DW+QW-1:0] w_lim, w_numx;

    logic           r_v   [0:QW];
    logic           r_en  [0:QW];
    logic           r_neg [0:QW];
    logic           r_ovf [0:QW];
    logic [QW-1:0]  r_q   [0:QW];
    logic [NW-1:0]  r_rem [0:QW-1];
    logic [DW-1:0]  r_den [0:QW-1];

    logic [QW-1:0]  w_qm;
    t_term          w_m;
    t_div_sts       r_sts;
    t_term          r_term;

    // operand forming
    assign w_mag   = i_num[NPW-1] ? MW'(-i_num) : MW'(i_num);
    assign n_p_num = NW'({w_mag, {SH{1'b0}}}) + NW'(i_dd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else begin
            r_p_v <= i_ctl.valid;
        end
        r_p_en  <= i_ctl.en;
        r_p_neg <= i_num[NPW-1];
        r_p_num <= n_p_num;
        r_p_den <= {i_dd, 1'b0};
    end

    // clip check: quotient above the limit
    assign w_numx = (DW+QW)'(r_p_num);
    assign w_lim  = ((DW+QW)'(r_p_den) << (QW - 1)) + (DW+QW)'(r_p_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_p_v;
        end
        r_en[0]  <= r_p_en;
        r_neg[0] <= r_p_neg;
        r_ovf[0] <= (w_numx >= w_lim);
        r_q[0]   <= '0;
        r_rem[0] <= r_p_num;
        r_den[0] <= r_p_den;
    end

    for (genvar j = 1; j <= QW; j++) begin : g_stage
        logic [DW+QW-1:0] w_dsh, w_remx;
        logic             w_ge;

        assign w_dsh  = (DW+QW)'(r_den[j-1]) << (QW - j);
        assign w_remx = (DW+QW)'(r_rem[j-1]);
        assign w_ge   = (w_remx >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= r_v[j-1];
            end
            r_en[j]  <= r_en[j-1];
            r_neg[j] <= r_neg[j-1];
            r_ovf[j] <= r_ovf[j-1];
            r_q[j]   <= {r_q[j-1][QW-2:0], w_ge};
        end

        if (j < QW) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[j] <= w_ge ? NW'(w_remx - w_dsh) : r_rem[j-1];
                r_den[j] <= r_den[j-1];
            end
        end
    end

    assign w_qm = r_ovf[QW] ? TERM_LIM : r_q[QW];
    assign w_m  = $signed({1'b0, w_qm});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sts <= '0;
        end else begin
            r_sts.valid <= r_v[QW];
            r_sts.sat   <= r_v[QW] && r_en[QW] && r_ovf[QW];
        end
        if (!r_en[QW]) begin
            r_term <= '0;
        end else if (r_neg[QW]) begin
            r_term <= -w_m;
        end else begin
            r_term <= w_m;
        end
    end

    assign o_sts  = r_sts;
    assign o_term = r_term;

`ifndef ASSERT_OFF
    a_lat: assert property (@(posedge i_clk) o_sts.valid |-> $past(i_ctl.valid, DIV_LAT))
        else $error("divider result without request");
    a_sat_lim: assert property (@(posedge i_clk) o_sts.sat |->
        (o_term == $signed({1'b0, TERM_LIM})) || (o_term == -$signed({1'b0, TERM_LIM})))
        else $error("clipped term not at limit");
    a_sat_v: assert property (@(posedge i_clk) o_sts.sat |-> o_sts.valid)
        else $error("clip flag without result");
`endif

endmodule
`default_nettype wire

[sv/box_iou_giou_gradient_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// box_iou_giou_gradient_core
// IoU / GIoU gradient of a predicted box against a truth box, fixed point.
//
//   channel   ports                         handshake
//   request   start, i_pred_*, i_truth_*    start & !busy
//   result    o_strobe, o_grad_*, o_saturated    o_strobe, one cycle
//   config    i_cfg_we, i_cfg_wdata         i_cfg_we
//
// one request per cycle
// 41 stage quotient pipelines, 8 in parallel
// busy stays low, the pipeline never stalls
// synchronous active low reset clears valid bits, giou_mode resets to 1
// ---------------------------------------------------------------------------
module box_iou_giou_gradient_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_pred_center_x,
    input  wire logic signed [15:0] i_pred_center_y,
    input  wire logic signed [15:0] i_pred_width,
    input  wire logic signed [15:0] i_pred_height,
    input  wire logic signed [15:0] i_truth_center_x,
    input  wire logic signed [15:0] i_truth_center_y,
    input  wire logic signed [15:0] i_truth_width,
    input  wire logic signed [15:0] i_truth_height,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    output logic                    o_strobe,
    output logic signed [31:0]      o_grad_top,
    output logic signed [31:0]      o_grad_bottom,
    output logic signed [31:0]      o_grad_left,
    output logic signed [31:0]      o_grad_right,
    output logic                    o_saturated
);
    import biggr_pkg::*;

    localparam int DQ  = AW - 1;
    localparam int DL  = 19;
    localparam int LAT = DIV_LAT + 8;

    logic r_giou_mode;

    // stage 1: edges
    logic r_v1, r_m1;
    logic signed [EW-1:0] r_rt1, r_rb1, r_rl1, r_rr1, r_tt1, r_tb1, r_tl1, r_tr1;
    // stage 2: ordered edges
    logic r_v2, r_m2, r_swv2, r_swh2;
    logic signed [EW-1:0] r_pt2, r_pb2, r_pl2, r_pr2, r_tt2, r_tb2, r_tl2, r_tr2;
    // stage 3: lengths
    logic r_v3, r_m3, r_swv3, r_swh3;
    logic signed [LW-1:0] r_hp3, r_wp3, r_ht3, r_wt3, r_ih3, r_iw3, r_cw3, r_ch3;
    logic [3:0] r_fi3, r_fc3;
    // stage 4: areas
    logic r_v4, r_m4, r_swv4, r_swh4;
    logic signed [AW-1:0] r_x4, r_xt4, r_i4, r_c4;
    logic signed [LW-1:0] r_dx4 [4];
    logic signed [LW-1:0] r_di4 [4];
    logic signed [LW-1:0] r_dc4 [4];
    logic signed [2*LW-1:0] w_x, w_xt, w_i, w_c;
    // stage 5: union
    logic r_v5, r_m5, r_swv5, r_swh5;
    logic signed [AW-1:0] r_u5, r_i5, r_c5;
    logic signed [LW-1:0] r_du5 [4];
    logic signed [LW-1:0] r_di5 [4];
    logic signed [LW-1:0] r_dc5 [4];
    // stage 6: products
    logic r_v6, r_swv6, r_swh6, r_eu6, r_ec6;
    logic signed [AW+LW-1:0] r_pa6 [4];
    logic signed [AW+LW-1:0] r_pb6 [4];
    logic signed [AW+LW-1:0] r_pc6 [4];
    logic signed [AW+LW-1:0] r_pe6 [4];
    logic [DQ+DL-1:0]    r_ul6, r_cl6;
    logic [2*DQ-DL-1:0]  r_uh6, r_ch6;
    logic [DQ-1:0]       w_du, w_dc;
    // stage 7: numerators and squared denominators
    logic r_v7, r_swv7, r_swh7, r_eu7, r_ec7;
    t_num r_n17 [4];
    t_num r_n27 [4];
    t_dd  r_ddu7, r_ddc7;

    t_div_ctl w_ctl_u, w_ctl_c;
    t_div_sts w_sts1 [4];
    t_div_sts w_sts2 [4];
    t_term    w_t1   [4];
    t_term    w_t2   [4];

    logic [1:0] r_swd [0:DIV_LAT-1];

    logic [GW-1:0] w_g [4];
    logic [3:0]    w_gs;
    logic [GW-1:0] r_g [4];
    logic          r_sat, r_strobe;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_giou_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_giou_mode <= i_cfg_wdata;
        end
    end

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        r_m1  <= r_giou_mode;
        r_rt1 <= (EW'(i_pred_center_y) <<< 1) - EW'(i_pred_height);
        r_rb1 <= (EW'(i_pred_center_y) <<< 1) + EW'(i_pred_height);
        r_rl1 <= (EW'(i_pred_center_x) <<< 1) - EW'(i_pred_width);
        r_rr1 <= (EW'(i_pred_center_x) <<< 1) + EW'(i_pred_width);
        r_tt1 <= (EW'(i_truth_center_y) <<< 1) - EW'(i_truth_height);
        r_tb1 <= (EW'(i_truth_center_y) <<< 1) + EW'(i_truth_height);
        r_tl1 <= (EW'(i_truth_center_x) <<< 1) - EW'(i_truth_width);
        r_tr1 <= (EW'(i_truth_center_x) <<< 1) + EW'(i_truth_width);
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        r_m2   <= r_m1;
        r_swv2 <= !(r_rt1 < r_rb1);
        r_swh2 <= !(r_rl1 < r_rr1);
        r_pt2  <= (r_rt1 < r_rb1) ? r_rt1 : r_rb1;
        r_pb2  <= (r_rt1 > r_rb1) ? r_rt1 : r_rb1;
        r_pl2  <= (r_rl1 < r_rr1) ? r_rl1 : r_rr1;
        r_pr2  <= (r_rl1 > r_rr1) ? r_rl1 : r_rr1;
        r_tt2  <= r_tt1;
        r_tb2  <= r_tb1;
        r_tl2  <= r_tl1;
        r_tr2  <= r_tr1;
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        r_m3   <= r_m2;
        r_swv3 <= r_swv2;
        r_swh3 <= r_swh2;
        r_hp3  <= LW'(r_pb2) - LW'(r_pt2);
        r_wp3  <= LW'(r_pr2) - LW'(r_pl2);
        r_ht3  <= LW'(r_tb2) - LW'(r_tt2);
        r_wt3  <= LW'(r_tr2) - LW'(r_tl2);
        r_ih3  <= LW'((r_pb2 < r_tb2) ? r_pb2 : r_tb2) - LW'((r_pt2 > r_tt2) ? r_pt2 : r_tt2);
        r_iw3  <= LW'((r_pr2 < r_tr2) ? r_pr2 : r_tr2) - LW'((r_pl2 > r_tl2) ? r_pl2 : r_tl2);
        r_cw3  <= LW'((r_pr2 > r_tr2) ? r_pr2 : r_tr2) - LW'((r_pl2 < r_tl2) ? r_pl2 : r_tl2);
        r_ch3  <= LW'((r_pb2 > r_tb2) ? r_pb2 : r_tb2) - LW'((r_pt2 < r_tt2) ? r_pt2 : r_tt2);
        r_fi3  <= {r_pr2 < r_tr2, r_pl2 > r_tl2, r_pb2 < r_tb2, r_pt2 > r_tt2};
        r_fc3  <= {r_pr2 > r_tr2, r_pl2 < r_tl2, r_pb2 > r_tb2, r_pt2 < r_tt2};
    end

    // stage 4
    assign w_x  = r_hp3 * r_wp3;
    assign w_xt = r_ht3 * r_wt3;
    assign w_i  = r_iw3 * r_ih3;
    assign w_c  = r_cw3 * r_ch3;

    always_ff @(posedge i_clk) begin
        r_m4     <= r_m3;
        r_swv4   <= r_swv3;
        r_swh4   <= r_swh3;
        r_x4     <= AW'(w_x);
        r_xt4    <= AW'(w_xt);
        r_i4     <= AW'(w_i);
        r_c4     <= AW'(w_c);
        r_dx4[0] <= -r_wp3;
        r_dx4[1] <= r_wp3;
        r_dx4[2] <= -r_hp3;
        r_dx4[3] <= r_hp3;
        r_di4[0] <= r_fi3[0] ? -r_iw3 : '0;
        r_di4[1] <= r_fi3[1] ? r_iw3 : '0;
        r_di4[2] <= r_fi3[2] ? -r_ih3 : '0;
        r_di4[3] <= r_fi3[3] ? r_ih3 : '0;
        r_dc4[0] <= r_fc3[0] ? -r_cw3 : '0;
        r_dc4[1] <= r_fc3[1] ? r_cw3 : '0;
        r_dc4[2] <= r_fc3[2] ? -r_ch3 : '0;
        r_dc4[3] <= r_fc3[3] ? r_ch3 : '0;
    end

    // stage 5
    always_ff @(posedge i_clk) begin
        r_m5   <= r_m4;
        r_swv5 <= r_swv4;
        r_swh5 <= r_swh4;
        r_u5   <= r_x4 + r_xt4 - r_i4;
        r_i5   <= r_i4;
        r_c5   <= r_c4;
        for (int k = 0; k < 4; k++) begin
            r_du5[k] <= r_dx4[k] - r_di4[k];
            r_di5[k] <= r_di4[k];
            r_dc5[k] <= r_dc4[k];
        end
    end

    // stage 6
    assign w_du = r_u5[DQ-1:0];
    assign w_dc = r_c5[DQ-1:0];

    always_ff @(posedge i_clk) begin
        r_swv6 <= r_swv5;
        r_swh6 <= r_swh5;
        r_eu6  <= !r_u5[AW-1] && (r_u5 != '0);
        r_ec6  <= r_m5 && !r_c5[AW-1] && (r_c5 != '0);
        for (int k = 0; k < 4; k++) begin
            r_pa6[k] <= r_u5 * r_di5[k];
            r_pb6[k] <= r_i5 * r_du5[k];
            r_pc6[k] <= r_c5 * r_du5[k];
            r_pe6[k] <= r_u5 * r_dc5[k];
        end
        r_ul6 <= w_du * w_du[DL-1:0];
        r_uh6 <= w_du * w_du[DQ-1:DL];
        r_cl6 <= w_dc * w_dc[DL-1:0];
        r_ch6 <= w_dc * w_dc[DQ-1:DL];
    end

    // stage 7
    always_ff @(posedge i_clk) begin
        r_swv7 <= r_swv6;
        r_swh7 <= r_swh6;
        r_eu7  <= r_eu6;
        r_ec7  <= r_ec6;
        for (int k = 0; k < 4; k++) begin
            r_n17[k] <= NPW'(r_pa6[k]) - NPW'(r_pb6[k]);
            r_n27[k] <= NPW'(r_pc6[k]) - NPW'(r_pe6[k]);
        end
        r_ddu7 <= DDW'(r_ul6) + (DDW'(r_uh6) << DL);
        r_ddc7 <= DDW'(r_cl6) + (DDW'(r_ch6) << DL);
    end

    always_comb begin
        w_ctl_u.valid = r_v7;
        w_ctl_u.en    = r_eu7;
        w_ctl_c.valid = r_v7;
        w_ctl_c.en    = r_ec7;
    end

    for (genvar k = 0; k < 4; k++) begin : g_edge
        biggr_div u_div_iou (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl_u),
            .i_num   (r_n17[k]),
            .i_dd    (r_ddu7),
            .o_sts   (w_sts1[k]),
            .o_term  (w_t1[k])
        );
        biggr_div u_div_giou (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl_c),
            .i_num   (r_n27[k]),
            .i_dd    (r_ddc7),
            .o_sts   (w_sts2[k]),
            .o_term  (w_t2[k])
        );
    end

    // swap flags follow the quotient pipelines
    always_ff @(posedge i_clk) begin
        r_swd[0] <= {r_swv7, r_swh7};
        for (int j = 1; j < DIV_LAT; j++) begin
            r_swd[j] <= r_swd[j-1];
        end
    end

    // sum and clip
    always_comb begin
        logic signed [SW-1:0] s;
        logic [SW-GW:0]       hi;
        for (int k = 0; k < 4; k++) begin
            s  = SW'(w_t1[k]) + SW'(w_t2[k]);
            hi = s[SW-1:GW-1];
            w_gs[k] = !((&hi) || !(|hi));
            if (w_gs[k]) begin
                w_g[k] = s[SW-1] ? G_MIN : G_MAX;
            end else begin
                w_g[k] = s[GW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_sts1[0].valid;
        end
        r_sat  <= (|w_gs) || w_sts1[0].sat || w_sts1[1].sat || w_sts1[2].sat
                  || w_sts1[3].sat || w_sts2[0].sat || w_sts2[1].sat
                  || w_sts2[2].sat || w_sts2[3].sat;
        r_g[0] <= r_swd[DIV_LAT-1][1] ? w_g[1] : w_g[0];
        r_g[1] <= r_swd[DIV_LAT-1][1] ? w_g[0] : w_g[1];
        r_g[2] <= r_swd[DIV_LAT-1][0] ? w_g[3] : w_g[2];
        r_g[3] <= r_swd[DIV_LAT-1][0] ? w_g[2] : w_g[3];
    end

    assign o_strobe      = r_strobe;
    assign o_grad_top    = r_g[0];
    assign o_grad_bottom = r_g[1];
    assign o_grad_left   = r_g[2];
    assign o_grad_right  = r_g[3];
    assign o_saturated   = r_sat;

`ifndef ASSERT_OFF
    a_lat: assert property (@(posedge i_clk) o_strobe |-> $past(start, LAT))
        else $error("result without request");
    a_div_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sts1[0].valid == w_sts2[0].valid) && (w_sts1[3].valid == w_sts2[3].valid))
        else $error("quotient pipelines out of step");
    a_cfg: assert property (@(posedge i_clk) i_rst_n && i_cfg_we |=>
        r_giou_mode == $past(i_cfg_wdata))
        else $error("mode write lost");
`endif

endmodule
`default_nettype wire

[tb/sv/box_iou_giou_gradient_core_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_iou_giou_gradient_core_test
// Self-checking bench of the IoU / GIoU gradient core: a directed table and
// random box pairs, checked in order against a fixed point gradient model or a
// typed row's expectation, with the giou_mode register switched between phases.
// ---------------------------------------------------------------------------
module box_iou_giou_gradient_core_test;

    typedef logic signed [15:0] t_box_in [8];

    typedef struct {
        logic signed [31:0] top;
        logic signed [31:0] bottom;
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic               sat;
    } t_grad;

    typedef struct {
        logic               mode;
        logic signed [15:0] f [8];
        bit                 typed;
        t_grad              exp;
    } t_row;

    localparam int IDLE_WAIT = 60;
    localparam int WDOG_LIM  = 4000;
    localparam longint TERM_CLIP = longint'(1) << 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] box [8];
    logic               i_cfg_we;
    logic               i_cfg_wdata;
    logic               o_strobe;
    logic signed [31:0] o_grad_top, o_grad_bottom, o_grad_left, o_grad_right;
    logic               o_saturated;

    t_grad  grad_q [$];
    logic   mode_mirror;
    bit     failed;
    bit     no_idle;
    int     quiet_cycles;
    t_row   rows [$];
    bit     row_typed;
    t_grad  row_exp;

    box_iou_giou_gradient_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_pred_center_x  (box[0]),
        .i_pred_center_y  (box[1]),
        .i_pred_width     (box[2]),
        .i_pred_height    (box[3]),
        .i_truth_center_x (box[4]),
        .i_truth_center_y (box[5]),
        .i_truth_width    (box[6]),
        .i_truth_height   (box[7]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_strobe         (o_strobe),
        .o_grad_top       (o_grad_top),
        .o_grad_bottom    (o_grad_bottom),
        .o_grad_left      (o_grad_left),
        .o_grad_right     (o_grad_right),
        .o_saturated      (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint lmin(longint a, longint b);
        return a < b ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return a > b ? a : b;
    endfunction

    // rounded |n| * 2^29 / d^2, clipped to 2^40
    function automatic longint rounded_quot(longint n, longint d, inout bit sat);
        logic [127:0] m, dd, q;
        m  = n < 0 ? 128'(-n) : 128'(n);
        dd = 128'(d) * 128'(d);
        q  = ((m << 30) + dd) / (dd << 1);
        if (q > 128'(TERM_CLIP)) begin
            q   = 128'(TERM_CLIP);
            sat = 1'b1;
        end
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_grad edge_gradients(t_box_in f, logic giou);
        longint rt, rb, rl, rr, tt, tb, tl, tr, pt, pb, pl, pr;
        longint x, xt, ih, iw, ia, u, cw, ch, c, du, s, tmp;
        longint dx [4], di [4], dc [4], g [4];
        bit     sat;
        t_grad  r;
        sat = 1'b0;
        rt = 2 * longint'(f[1]) - f[3];  rb = 2 * longint'(f[1]) + f[3];
        rl = 2 * longint'(f[0]) - f[2];  rr = 2 * longint'(f[0]) + f[2];
        tt = 2 * longint'(f[5]) - f[7];  tb = 2 * longint'(f[5]) + f[7];
        tl = 2 * longint'(f[4]) - f[6];  tr = 2 * longint'(f[4]) + f[6];
        pt = lmin(rt, rb);  pb = lmax(rt, rb);
        pl = lmin(rl, rr);  pr = lmax(rl, rr);
        x  = (pb - pt) * (pr - pl);
        xt = (tb - tt) * (tr - tl);
        ih = lmin(pb, tb) - lmax(pt, tt);
        iw = lmin(pr, tr) - lmax(pl, tl);
        ia = iw * ih;
        u  = x + xt - ia;
        cw = lmax(pr, tr) - lmin(pl, tl);
        ch = lmax(pb, tb) - lmin(pt, tt);
        c  = cw * ch;
        dx[0] = -(pr - pl);  dx[1] = pr - pl;
        dx[2] = -(pb - pt);  dx[3] = pb - pt;
        di[0] = pt > tt ? -iw : 0;  di[1] = pb < tb ? iw : 0;
        di[2] = pl > tl ? -ih : 0;  di[3] = pr < tr ? ih : 0;
        dc[0] = pt < tt ? -cw : 0;  dc[1] = pb > tb ? cw : 0;
        dc[2] = pl < tl ? -ch : 0;  dc[3] = pr > tr ? ch : 0;
        for (int k = 0; k < 4; k++) begin
            du = dx[k] - di[k];
            s  = 0;
            if (u > 0) s += rounded_quot(u * di[k] - ia * du, u, sat);
            if (giou && c > 0) s += rounded_quot(c * du - u * dc[k], c, sat);
            if (s > 64'sd2147483647) begin s = 64'sd2147483647; sat = 1'b1; end
            if (s < -64'sd2147483648) begin s = -64'sd2147483648; sat = 1'b1; end
            g[k] = s;
        end
        if (!(rt < rb)) begin tmp = g[0]; g[0] = g[1]; g[1] = tmp; end
        if (!(rl < rr)) begin tmp = g[2]; g[2] = g[3]; g[3] = tmp; end
        r.top = 32'(g[0]);  r.bottom = 32'(g[1]);
        r.left = 32'(g[2]); r.right = 32'(g[3]);
        r.sat = sat;
        return r;
    endfunction

    // request predictor, result checker, mode mirror and watchdog
    always @(posedge i_clk) begin
        t_box_in f;
        t_grad   e;
        if (i_rst_n) begin
            quiet_cycles = quiet_cycles + 1;
            if (start && !busy) begin
                for (int k = 0; k < 8; k++) f[k] = box[k];
                e = edge_gradients(f, mode_mirror);
                if (row_typed) e = row_exp;
                grad_q.insert(grad_q.size(), e);
                quiet_cycles = 0;
            end
            if (o_strobe) begin
                quiet_cycles = 0;
                if (grad_q.size() == 0) begin
                    $error("result with nothing expected");
                    failed = 1'b1;
                end else begin
                    e = grad_q.pop_front();
                    if (o_grad_top !== e.top) begin
                        $error("grad_top exp %0d got %0d", e.top, o_grad_top);
                        failed = 1'b1;
                    end
                    if (o_grad_bottom !== e.bottom) begin
                        $error("grad_bottom exp %0d got %0d", e.bottom, o_grad_bottom);
                        failed = 1'b1;
                    end
                    if (o_grad_left !== e.left) begin
                        $error("grad_left exp %0d got %0d", e.left, o_grad_left);
                        failed = 1'b1;
                    end
                    if (o_grad_right !== e.right) begin
                        $error("grad_right exp %0d got %0d", e.right, o_grad_right);
                        failed = 1'b1;
                    end
                    if (o_saturated !== e.sat) begin
                        $error("saturated exp %0d got %0d", e.sat, o_saturated);
                        failed = 1'b1;
                    end
                end
            end
            if (i_cfg_we) mode_mirror = i_cfg_wdata;
            if (quiet_cycles >= WDOG_LIM) begin
                $display("[box_iou_giou_gradient_core] ERROR");
                $finish;
            end
        end
    end

    task automatic send_request(logic signed [15:0] f [8]);
        while (!no_idle && $urandom_range(99) < 25) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        for (int k = 0; k < 8; k++) box[k] <= f[k];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_mode(logic m);
        start <= 1'b0;
        @(posedge i_clk);
        while (grad_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_row(logic m, int a0, int a1, int a2, int a3,
                           int b0, int b1, int b2, int b3, bit typed);
        t_row r;
        r.mode = m;
        r.f[0] = 16'(a0); r.f[1] = 16'(a1); r.f[2] = 16'(a2); r.f[3] = 16'(a3);
        r.f[4] = 16'(b0); r.f[5] = 16'(b1); r.f[6] = 16'(b2); r.f[7] = 16'(b3);
        r.typed = typed;
        r.exp = '{top: 0, bottom: 0, left: 0, right: 0, sat: 0};
        rows.insert(rows.size(), r);
    endtask

    initial begin
        logic signed [15:0] f [8];
        logic               cur_mode;
        failed       = 1'b0;
        no_idle      = 1'b0;
        quiet_cycles = 0;
        mode_mirror  = 1'b1;
        cur_mode     = 1'b1;
        row_typed    = 1'b0;
        row_exp      = '{top: 0, bottom: 0, left: 0, right: 0, sat: 0};
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 1'b0;
        for (int k = 0; k < 8; k++) box[k] = '0;

        // all-zero boxes give zero area everywhere, so no term contributes
        add_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        add_row(1, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0);
        add_row(1, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0);
        add_row(1, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, 0);
        add_row(1, 0, 0, 4096, 4096, 0, 0, 4096, 4096, 0);
        add_row(1, 0, 0, 4096, 4096, 100, -50, 2048, 6000, 0);
        add_row(1, -8000, -8000, 2000, 2000, 8000, 8000, 2000, 2000, 0);
        add_row(1, 0, 0, 4096, 4096, 500, 300, -3000, -2000, 0);
        add_row(1, 0, 0, 0, 4096, 0, 0, 4096, 4096, 0);
        add_row(1, 0, 0, 4096, 0, 0, 0, 4096, 4096, 0);
        add_row(1, 100, 200, -3000, -1500, 0, 0, 4096, 4096, 0);
        add_row(1, 0, 0, 32767, 32767, 0, 0, 1, 1, 0);
        add_row(1, 0, 0, 1, 1, 0, 0, 1, 1, 0);
        add_row(1, 0, 0, 1, 1, 16000, 16000, 1, 1, 0);
        add_row(1, 0, 0, 16000, 16000, 100, 100, 2000, 2000, 0);
        add_row(0, 0, 0, 4096, 4096, 100, -50, 2048, 6000, 0);
        add_row(0, -8000, -8000, 2000, 2000, 8000, 8000, 2000, 2000, 0);
        add_row(0, 0, 0, 32767, 32767, 0, 0, 1, 1, 0);
        add_row(0, 0, 0, 0, 4096, 0, 0, 4096, 4096, 0);
        add_row(0, 32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].mode != cur_mode) begin
                set_mode(rows[r].mode);
                cur_mode = rows[r].mode;
            end
            row_typed <= rows[r].typed;
            row_exp   <= rows[r].exp;
            send_request(rows[r].f);
        end
        row_typed <= 1'b0;

        for (int n = 0; n < 1050; n++) begin
            if (n % 150 == 0) begin
                set_mode(n == 0 ? 1'b1 : ((n / 150) % 2 == 0));
            end
            no_idle = (n >= 300 && n < 450);
            if ($urandom_range(99) < 80) begin
                for (int k = 0; k < 8; k++) begin
                    if (k == 2 || k == 3 || k == 6 || k == 7)
                        f[k] = 16'($urandom_range(16384, 1));
                    else
                        f[k] = 16'($signed($urandom_range(16384)) - 8192);
                end
                if ($urandom_range(9) == 0) f[$urandom_range(7)] = '0;
            end else begin
                for (int k = 0; k < 8; k++) f[k] = 16'($urandom());
            end
            send_request(f);
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (grad_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (!failed) begin
            $display("[box_iou_giou_gradient_core] OK");
        end else begin
            $display("[box_iou_giou_gradient_core] ERROR");
        end
        $finish;
    end

endmodule
